// File: hdl/triangle_scanline_span_generator_core_assert.svh
// assertion macros shared by the span generator rtl
// expects clk and rst_n in the scope where a macro is used
`ifndef TRIANGLE_SCANLINE_SPAN_GENERATOR_CORE_ASSERT_SVH
`define TRIANGLE_SCANLINE_SPAN_GENERATOR_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define TSSG_ASSERT_IMP(lbl, ante, cons) lbl: assert property (@(posedge clk) \
  disable iff (!rst_n) (ante) |-> (cons)) else $error("tssg assertion failed");
`define TSSG_ASSERT_NXT(lbl, ante, cons) lbl: assert property (@(posedge clk) \
  disable iff (!rst_n) (ante) |=> (cons)) else $error("tssg assertion failed");
`else
`define TSSG_ASSERT_IMP(lbl, ante, cons)
`define TSSG_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// File: hdl/tssg_pkg.sv
// types and constants of the triangle span generator
// no dependencies
`default_nettype none
package tssg_pkg;
  localparam int SLOPE_FRAC = 16;
  localparam int RATIO_FRAC = 30;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 23;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROW_STEP   = 3'd0,
    CFG_MIN_HEIGHT = 3'd1,
    CFG_RED        = 3'd2,
    CFG_GREEN      = 3'd3,
    CFG_BLUE       = 3'd4
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RATIO_GO, ST_RATIO_WAIT, ST_SPLIT_MUL, ST_SPLIT_FIN, ST_HALF,
    ST_SLOPE_GO, ST_SLOPE_WAIT, ST_DELTA, ST_WALK, ST_FLUSH
  } state_t;

  typedef enum logic [1:0] {
    MODE_NONE, MODE_FTOP, MODE_FBOT, MODE_SPLIT
  } mode_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;
endpackage
`default_nettype wire

// File: hdl/tssg_ifs.sv
// valid/ready channel interfaces for triangles in and spans out
// depends on nothing
`default_nettype none
interface tssg_in_if #(parameter int COORD_BITS = 24);
  logic valid;
  logic ready;
  logic signed [COORD_BITS-1:0] vert_a_x, vert_a_y, vert_a_z;
  logic signed [COORD_BITS-1:0] vert_b_x, vert_b_y, vert_b_z;
  logic signed [COORD_BITS-1:0] vert_c_x, vert_c_y, vert_c_z;
  modport source(output valid, vert_a_x, vert_a_y, vert_a_z, vert_b_x, vert_b_y,
                 vert_b_z, vert_c_x, vert_c_y, vert_c_z, input ready);
  modport sink(input valid, vert_a_x, vert_a_y, vert_a_z, vert_b_x, vert_b_y,
               vert_b_z, vert_c_x, vert_c_y, vert_c_z, output ready);
endinterface

interface tssg_out_if #(parameter int COORD_BITS = 24);
  logic valid;
  logic ready;
  logic signed [COORD_BITS-1:0] span_y, span_start_x, span_start_z;
  logic signed [COORD_BITS-1:0] span_end_x, span_end_z;
  logic [7:0] span_red, span_green, span_blue;
  logic last_span;
  logic truncated;
  modport source(output valid, span_y, span_start_x, span_start_z, span_end_x,
                 span_end_z, span_red, span_green, span_blue, last_span, truncated,
                 input ready);
  modport sink(input valid, span_y, span_start_x, span_start_z, span_end_x,
               span_end_z, span_red, span_green, span_blue, last_span, truncated,
               output ready);
endinterface
`default_nettype wire

// File: hdl/tssg_div.sv
// iterative restoring divider, one quotient bit per cycle
// depends on tssg_pkg
`default_nettype none
module tssg_div #(
  parameter int NW = 54,
  parameter int DW = 24
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  input  wire logic [NW-1:0]   num,
  input  wire logic [DW-1:0]   den,
  output tssg_pkg::div_stat_t  stat,
  output logic      [NW-1:0]   quo
);
  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] q_r;
  logic [DW-1:0] rem_r, den_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r, done_r;
  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          take;

  assign trial = {rem_r, q_r[NW-1]};
  assign diff  = trial - {1'b0, den_r};
  assign take  = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(NW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      q_r   <= {q_r[NW-2:0], take};
      rem_r <= take ? diff[DW-1:0] : trial[DW-1:0];
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quo       = q_r;
endmodule
`default_nettype wire

// File: hdl/triangle_scanline_span_generator_core.sv
// Work per triangle: a split triangle first finds its split point through the ratio
// division, then each half runs four slope divisions before its first span;
// every division goes through the single shared divider.
// Spans then leave at one per cycle while the receiver is ready; a triangle takes one item at a time, ready only idle.
// Reset (synchronous, rst_n low): idle, no spans pending, registers at defaults.
`default_nettype none
`include "triangle_scanline_span_generator_core_assert.svh"
module triangle_scanline_span_generator_core #(
  parameter int MAX_SPANS  = 64,
  parameter int COORD_BITS = 24,
  parameter int FRAC_BITS  = 8
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  tssg_in_if.sink                                 in_if,
  tssg_out_if.source                              out_if,
  input  wire logic                               cfg_we,
  input  wire logic [tssg_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [tssg_pkg::CFG_DATA_W-1:0]    cfg_data
);
  localparam int C    = COORD_BITS;
  localparam int NW   = C + tssg_pkg::RATIO_FRAC;
  localparam int SW   = 34;
  localparam int MA   = (C + 1 > 32) ? C + 1 : 32;
  localparam int PW   = MA + 32;
  localparam int CNTW = $clog2(MAX_SPANS + 1);
  localparam logic signed [SW-1:0] CMAX = SW'((64'sd1 <<< (C - 1)) - 64'sd1);
  localparam logic signed [SW-1:0] CMIN = -CMAX - SW'(1);
  localparam logic [16:0] ONE = 17'(1 << FRAC_BITS);

  typedef struct packed {
    logic signed [C-1:0] y;
    logic signed [C-1:0] sx;
    logic signed [C-1:0] sz;
    logic signed [C-1:0] ex;
    logic signed [C-1:0] ez;
    logic [7:0]          red;
    logic [7:0]          green;
    logic [7:0]          blue;
  } span_t;

  typedef struct packed {
    logic signed [C-1:0] x;
    logic signed [C-1:0] y;
    logic signed [C-1:0] z;
  } vtx_t;

  function automatic logic signed [C-1:0] sat_c(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] r;
    r = (v > CMAX) ? CMAX : ((v < CMIN) ? CMIN : v);
    return r[C-1:0];
  endfunction

  // configuration
  logic [15:0] row_step_r;
  logic [22:0] min_h_r;
  logic [7:0]  red_r, green_r, blue_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_step_r <= 16'd256;
      min_h_r    <= '0;
      red_r      <= 8'd255;
      green_r    <= 8'd255;
      blue_r     <= 8'd255;
    end else if (cfg_we) begin
      case (cfg_index)
        tssg_pkg::CFG_ROW_STEP:   row_step_r <= cfg_data[15:0];
        tssg_pkg::CFG_MIN_HEIGHT: min_h_r    <= cfg_data[22:0];
        tssg_pkg::CFG_RED:        red_r      <= cfg_data[7:0];
        tssg_pkg::CFG_GREEN:      green_r    <= cfg_data[7:0];
        tssg_pkg::CFG_BLUE:       blue_r     <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // classify the incoming triangle
  vtx_t        iv [3];
  logic [1:0]  ti, bi, t0, b0, tsec, bsec, mi;
  logic [1:0]  tcnt, bcnt;
  logic        all_eq;
  tssg_pkg::mode_t cls_mode;
  vtx_t        cls_m;

  always_comb begin
    iv[0] = '{in_if.vert_a_x, in_if.vert_a_y, in_if.vert_a_z};
    iv[1] = '{in_if.vert_b_x, in_if.vert_b_y, in_if.vert_b_z};
    iv[2] = '{in_if.vert_c_x, in_if.vert_c_y, in_if.vert_c_z};
    t0 = (iv[1].y > iv[0].y) ? 2'd1 : 2'd0;
    ti = (iv[2].y > iv[t0].y) ? 2'd2 : t0;
    b0 = (iv[1].y < iv[0].y) ? 2'd1 : 2'd0;
    bi = (iv[2].y < iv[b0].y) ? 2'd2 : b0;
    tcnt = 2'(iv[0].y == iv[ti].y) + 2'(iv[1].y == iv[ti].y) + 2'(iv[2].y == iv[ti].y);
    bcnt = 2'(iv[0].y == iv[bi].y) + 2'(iv[1].y == iv[bi].y) + 2'(iv[2].y == iv[bi].y);
    all_eq = iv[ti].y == iv[bi].y;
    // first other vertex sharing the extreme height
    if (ti != 2'd0 && iv[0].y == iv[ti].y) tsec = 2'd0;
    else if (ti != 2'd1 && iv[1].y == iv[ti].y) tsec = 2'd1;
    else tsec = 2'd2;
    if (bi != 2'd0 && iv[0].y == iv[bi].y) bsec = 2'd0;
    else if (bi != 2'd1 && iv[1].y == iv[bi].y) bsec = 2'd1;
    else bsec = 2'd2;
    mi = 2'(2'd3 - ti - bi);
    if (all_eq) begin
      cls_mode = tssg_pkg::MODE_NONE;
      cls_m    = iv[mi];
    end else if (tcnt == 2'd2) begin
      cls_mode = tssg_pkg::MODE_FTOP;
      cls_m    = iv[tsec];
    end else if (bcnt == 2'd2) begin
      cls_mode = tssg_pkg::MODE_FBOT;
      cls_m    = iv[bsec];
    end else begin
      cls_mode = tssg_pkg::MODE_SPLIT;
      cls_m    = iv[mi];
    end
  end

  // sequencer and datapath registers
  tssg_pkg::state_t state_r, state_nxt;
  tssg_pkg::mode_t  mode_r;
  vtx_t                top_r, bot_r, mid_r;
  logic signed [C-1:0] sx_r, sz_r;
  logic [30:0]         ratio_r;
  logic signed [PW-1:0] prod_r;
  logic signed [31:0]  slope_r [4];
  logic signed [31:0]  delta_r [4];
  logic signed [C-1:0] epos_r [4];
  logic signed [C-1:0] row_r;
  logic [CNTW-1:0]     spans_r;
  logic                cut_r, half_r, sel_r, neg_r;
  logic [1:0]          k_r;
  span_t               pend_r, out_r;
  logic                pend_valid_r, out_valid_r, out_last_r, out_trunc_r;

  // current half
  vtx_t                p0, ap;
  logic signed [C-1:0] p1x, p1z;
  logic                up;
  logic [16:0]         marg;

  always_comb begin
    p0 = top_r; p1x = mid_r.x; p1z = mid_r.z; ap = bot_r; up = 1'b0;
    marg = {1'b0, row_step_r};
    case (mode_r)
      tssg_pkg::MODE_FBOT: begin
        p0 = bot_r; ap = top_r; up = 1'b1; marg = ONE;
      end
      tssg_pkg::MODE_SPLIT: begin
        p0 = mid_r; p1x = sx_r; p1z = sz_r; marg = ONE;
        ap = half_r ? bot_r : top_r;
        up = !half_r;
      end
      default: ;
    endcase
  end

  logic signed [SW-1:0] h, habs, d, dabs, rt, rb, rsum, rstep, apy, more_lim;
  logic signed [C-1:0]  row_new;
  logic signed [C-1:0]  epos_new [4];
  logic                 short_half, more;

  always_comb begin
    h    = SW'(p0.y) - SW'(ap.y);
    habs = h[SW-1] ? -h : h;
    short_half = habs <= SW'(signed'({1'b0, min_h_r}));
    case (k_r)
      2'd0:    d = SW'(p0.x) - SW'(ap.x);
      2'd1:    d = SW'(p0.z) - SW'(ap.z);
      2'd2:    d = SW'(p1x) - SW'(ap.x);
      default: d = SW'(p1z) - SW'(ap.z);
    endcase
    dabs = d[SW-1] ? -d : d;
    rt = SW'(top_r.y) - SW'(mid_r.y);
    rb = SW'(top_r.y) - SW'(bot_r.y);
    rstep = SW'(signed'({1'b0, row_step_r}));
    rsum  = up ? SW'(row_r) + rstep : SW'(row_r) - rstep;
    row_new = sat_c(rsum);
    apy = SW'(ap.y);
    more_lim = up ? apy - SW'(signed'({1'b0, marg})) : apy + SW'(signed'({1'b0, marg}));
    more = up ? (SW'(row_new) < more_lim) : (SW'(row_new) > more_lim);
    for (int i = 0; i < 4; i++) begin
      epos_new[i] = sat_c(up ? SW'(epos_r[i]) + SW'(delta_r[i])
                             : SW'(epos_r[i]) - SW'(delta_r[i]));
    end
  end

  // shared divider
  tssg_pkg::div_stat_t div_stat;
  logic                div_start;
  logic [NW-1:0]       div_num, div_quo;
  logic [C-1:0]        div_den;

  assign div_num = (state_r == tssg_pkg::ST_RATIO_GO)
                 ? (NW'(rt[C-1:0]) << tssg_pkg::RATIO_FRAC)
                 : (NW'(dabs[C-1:0]) << tssg_pkg::SLOPE_FRAC);
  assign div_den = (state_r == tssg_pkg::ST_RATIO_GO) ? rb[C-1:0] : habs[C-1:0];

  tssg_div #(.NW(NW), .DW(C)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num), .den(div_den),
    .stat(div_stat), .quo(div_quo)
  );

  logic signed [31:0] slope_sat;
  logic               ovp, ovn;
  assign ovp = |div_quo[NW-1:31];
  assign ovn = (|div_quo[NW-1:32]) || (div_quo[31] && (|div_quo[30:0]));
  assign slope_sat = neg_r ? (ovn ? 32'sh8000_0000 : -signed'(div_quo[31:0]))
                           : (ovp ? 32'sh7fff_ffff : signed'(div_quo[31:0]));

  // shared multiplier
  logic signed [MA-1:0] mul_a;
  logic signed [31:0]   mul_b;
  logic signed [PW-1:0] mul_p;
  logic signed [C:0]    split_d;
  logic signed [SW-1:0] split_v;

  always_comb begin
    split_d = sel_r ? (C+1)'(top_r.z) - (C+1)'(bot_r.z)
                    : (C+1)'(top_r.x) - (C+1)'(bot_r.x);
    if (state_r == tssg_pkg::ST_DELTA) begin
      mul_a = MA'(slope_r[k_r]);
      mul_b = signed'({16'b0, row_step_r});
    end else begin
      mul_a = MA'(split_d);
      mul_b = signed'({1'b0, ratio_r});
    end
    mul_p = PW'(mul_a) * PW'(mul_b);
    split_v = (sel_r ? SW'(top_r.z) : SW'(top_r.x))
            - SW'(prod_r >>> tssg_pkg::RATIO_FRAC);
  end

  // next state and strobes
  logic out_free, emit, flush, cut_set, half_adv, out_load;
  assign out_free = !out_valid_r || out_if.ready;

  always_comb begin
    state_nxt = state_r;
    div_start = 1'b0;
    emit = 1'b0; flush = 1'b0; cut_set = 1'b0; half_adv = 1'b0;
    case (state_r)
      tssg_pkg::ST_IDLE:
        if (in_if.valid) begin
          case (cls_mode)
            tssg_pkg::MODE_NONE:  state_nxt = tssg_pkg::ST_FLUSH;
            tssg_pkg::MODE_SPLIT: state_nxt = tssg_pkg::ST_RATIO_GO;
            default:              state_nxt = tssg_pkg::ST_HALF;
          endcase
        end
      tssg_pkg::ST_RATIO_GO: begin
        div_start = 1'b1;
        state_nxt = tssg_pkg::ST_RATIO_WAIT;
      end
      tssg_pkg::ST_RATIO_WAIT:
        if (div_stat.done) state_nxt = tssg_pkg::ST_SPLIT_MUL;
      tssg_pkg::ST_SPLIT_MUL: state_nxt = tssg_pkg::ST_SPLIT_FIN;
      tssg_pkg::ST_SPLIT_FIN:
        state_nxt = sel_r ? tssg_pkg::ST_HALF : tssg_pkg::ST_SPLIT_MUL;
      tssg_pkg::ST_HALF:
        if (short_half) begin
          if (mode_r == tssg_pkg::MODE_SPLIT && !half_r) half_adv = 1'b1;
          else state_nxt = tssg_pkg::ST_FLUSH;
        end else begin
          state_nxt = tssg_pkg::ST_SLOPE_GO;
        end
      tssg_pkg::ST_SLOPE_GO: begin
        div_start = 1'b1;
        state_nxt = tssg_pkg::ST_SLOPE_WAIT;
      end
      tssg_pkg::ST_SLOPE_WAIT:
        if (div_stat.done)
          state_nxt = (k_r == 2'd3) ? tssg_pkg::ST_DELTA : tssg_pkg::ST_SLOPE_GO;
      tssg_pkg::ST_DELTA:
        if (k_r == 2'd3) state_nxt = tssg_pkg::ST_WALK;
      tssg_pkg::ST_WALK: begin
        if (spans_r == CNTW'(MAX_SPANS)) begin
          cut_set = 1'b1;
        end else if (!pend_valid_r || out_free) begin
          emit = 1'b1;
        end
        if (cut_set || (emit && !more)) begin
          if (mode_r == tssg_pkg::MODE_SPLIT && !half_r) begin
            half_adv  = 1'b1;
            state_nxt = tssg_pkg::ST_HALF;
          end else begin
            state_nxt = tssg_pkg::ST_FLUSH;
          end
        end
      end
      tssg_pkg::ST_FLUSH:
        if (!pend_valid_r) state_nxt = tssg_pkg::ST_IDLE;
        else if (out_free) begin
          flush     = 1'b1;
          state_nxt = tssg_pkg::ST_IDLE;
        end
      default: state_nxt = tssg_pkg::ST_IDLE;
    endcase
  end

  assign out_load = (emit && pend_valid_r) || flush;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= tssg_pkg::ST_IDLE;
    else        state_r <= state_nxt;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spans_r      <= '0;
      cut_r        <= 1'b0;
      half_r       <= 1'b0;
      sel_r        <= 1'b0;
      k_r          <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      mode_r       <= tssg_pkg::MODE_NONE;
    end else begin
      if (state_r == tssg_pkg::ST_IDLE && in_if.valid) begin
        mode_r  <= cls_mode;
        spans_r <= '0;
        cut_r   <= 1'b0;
        half_r  <= 1'b0;
        sel_r   <= 1'b0;
        k_r     <= '0;
      end
      if (state_r == tssg_pkg::ST_SPLIT_FIN) sel_r <= ~sel_r;
      if (state_r == tssg_pkg::ST_HALF) k_r <= '0;
      if ((state_r == tssg_pkg::ST_SLOPE_WAIT && div_stat.done)
          || state_r == tssg_pkg::ST_DELTA) k_r <= k_r + 2'd1;
      if (half_adv) half_r <= 1'b1;
      if (cut_set) cut_r <= 1'b1;
      if (emit) begin
        spans_r      <= spans_r + CNTW'(1);
        pend_valid_r <= 1'b1;
      end else if (flush) begin
        pend_valid_r <= 1'b0;
      end
      if (out_load)          out_valid_r <= 1'b1;
      else if (out_if.ready) out_valid_r <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state_r == tssg_pkg::ST_IDLE && in_if.valid) begin
      top_r <= iv[ti];
      bot_r <= iv[bi];
      mid_r <= cls_m;
    end
    if (state_r == tssg_pkg::ST_RATIO_WAIT && div_stat.done) ratio_r <= div_quo[30:0];
    if (state_r == tssg_pkg::ST_SPLIT_MUL) prod_r <= mul_p;
    if (state_r == tssg_pkg::ST_SPLIT_FIN) begin
      if (sel_r) sz_r <= sat_c(split_v);
      else       sx_r <= sat_c(split_v);
    end
    if (state_r == tssg_pkg::ST_HALF) begin
      epos_r[0] <= p0.x;
      epos_r[1] <= p0.z;
      epos_r[2] <= p1x;
      epos_r[3] <= p1z;
      row_r     <= p0.y;
    end
    if (state_r == tssg_pkg::ST_SLOPE_GO) neg_r <= d[SW-1] ^ h[SW-1];
    if (state_r == tssg_pkg::ST_SLOPE_WAIT && div_stat.done) slope_r[k_r] <= slope_sat;
    if (state_r == tssg_pkg::ST_DELTA)
      delta_r[k_r] <= 32'(mul_p >>> tssg_pkg::SLOPE_FRAC);
    if (emit) begin
      pend_r <= '{row_r, epos_r[0], epos_r[1], epos_r[2], epos_r[3],
                  red_r, green_r, blue_r};
      row_r  <= row_new;
      for (int i = 0; i < 4; i++) epos_r[i] <= epos_new[i];
    end
    if (out_load) begin
      out_r       <= pend_r;
      out_last_r  <= flush;
      out_trunc_r <= flush && cut_r;
    end
  end

  assign in_if.ready         = state_r == tssg_pkg::ST_IDLE;
  assign out_if.valid        = out_valid_r;
  assign out_if.span_y       = out_r.y;
  assign out_if.span_start_x = out_r.sx;
  assign out_if.span_start_z = out_r.sz;
  assign out_if.span_end_x   = out_r.ex;
  assign out_if.span_end_z   = out_r.ez;
  assign out_if.span_red     = out_r.red;
  assign out_if.span_green   = out_r.green;
  assign out_if.span_blue    = out_r.blue;
  assign out_if.last_span    = out_last_r;
  assign out_if.truncated    = out_trunc_r;

  `TSSG_ASSERT_IMP(a_idle_no_pend, state_r == tssg_pkg::ST_IDLE, !pend_valid_r)
  `TSSG_ASSERT_IMP(a_trunc_on_last, out_valid_r && out_trunc_r, out_last_r)
  `TSSG_ASSERT_IMP(a_span_bound, 1'b1, spans_r <= CNTW'(MAX_SPANS))
  `TSSG_ASSERT_NXT(a_div_runs, div_start, div_stat.busy)
endmodule
`default_nettype wire

// File: bench/testbench.sv
// self-checking bench for the triangle scanline span generator core
// depends on tssg_pkg, the tssg_in_if/tssg_out_if interfaces and the core rtl
// triangles go in on one channel, spans are predicted and checked on the other
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_SPANS  = 64;
  localparam int COORD_BITS = 24;
  localparam int FRAC_BITS  = 8;
  localparam longint COORD_MAX = (longint'(1) << (COORD_BITS - 1)) - 1;
  localparam longint COORD_MIN = -COORD_MAX - 1;
  localparam int SETTLE_CYCLES = 700;
  localparam int HOLD_CYCLES   = 400;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef struct { coord_t p[3][3]; } tri_t;
  typedef struct packed {
    coord_t     y, start_x, start_z, end_x, end_z;
    logic [7:0] red, green, blue;
    logic       last, trunc;
  } span_t;

  class span_scoreboard;
    int unsigned row_step = 256, min_height = 0;
    logic [7:0] red = 8'hff, green = 8'hff, blue = 8'hff;
    span_t spans_due[$];
    span_t fresh[$];
    longint pos[4];
    bit cut;
    int errors;

    function longint clamp(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function longint slope_of(longint d, longint h);
      if (h == 0) return 0;
      return clamp((d * 65536) / h, -(longint'(1) << 31), (longint'(1) << 31) - 1);
    endfunction

    function void walk_half(input longint s0[3], input longint s1[3], input longint f[3],
                            input bit up, input longint margin);
      longint h, row;
      longint delta[4];
      longint sl[4];
      span_t s;
      bit more;
      h = s0[1] - f[1];
      if ((h < 0 ? -h : h) <= longint'(min_height)) return;
      pos[0] = s0[0]; pos[1] = s0[2]; pos[2] = s1[0]; pos[3] = s1[2];
      sl[0] = slope_of(s0[0] - f[0], h);
      sl[1] = slope_of(s0[2] - f[2], h);
      sl[2] = slope_of(s1[0] - f[0], h);
      sl[3] = slope_of(s1[2] - f[2], h);
      for (int i = 0; i < 4; i++)
        delta[i] = (sl[i] * longint'(row_step)) >>> tssg_pkg::SLOPE_FRAC;
      row = s0[1];
      forever begin
        if (fresh.size() >= MAX_SPANS) begin
          cut = 1;
          return;
        end
        s.y = row[COORD_BITS-1:0];
        s.start_x = pos[0][COORD_BITS-1:0];
        s.start_z = pos[1][COORD_BITS-1:0];
        s.end_x = pos[2][COORD_BITS-1:0];
        s.end_z = pos[3][COORD_BITS-1:0];
        s.red = red; s.green = green; s.blue = blue;
        s.last = 0; s.trunc = 0;
        fresh.push_back(s);
        if (up) begin
          row = clamp(row + row_step, COORD_MIN, COORD_MAX);
          for (int i = 0; i < 4; i++) pos[i] = clamp(pos[i] + delta[i], COORD_MIN, COORD_MAX);
          more = row < f[1] - margin;
        end else begin
          row = clamp(row - row_step, COORD_MIN, COORD_MAX);
          for (int i = 0; i < 4; i++) pos[i] = clamp(pos[i] - delta[i], COORD_MIN, COORD_MAX);
          more = row > f[1] + margin;
        end
        if (!more) break;
      end
    endfunction

    function void note_triangle(tri_t t);
      longint v[3][3];
      longint sp[3];
      longint one, ht, r;
      int ti, bi, mi, tc, bc, ts, bs;
      one = longint'(1) << FRAC_BITS;
      ti = 0; bi = 0; mi = -1; tc = 0; bc = 0; ts = -1; bs = -1;
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++) v[i][j] = longint'(t.p[i][j]);
      fresh.delete();
      cut = 0;
      for (int i = 1; i < 3; i++) begin
        if (v[i][1] > v[ti][1]) ti = i;
        if (v[i][1] < v[bi][1]) bi = i;
      end
      for (int i = 0; i < 3; i++) begin
        if (v[i][1] == v[ti][1]) begin
          tc++;
          if (i != ti && ts < 0) ts = i;
        end
        if (v[i][1] == v[bi][1]) begin
          bc++;
          if (i != bi && bs < 0) bs = i;
        end
      end
      if (tc == 2 && ts >= 0) begin
        walk_half(v[ti], v[ts], v[bi], 0, longint'(row_step));
      end else if (bc == 2 && bs >= 0) begin
        walk_half(v[bi], v[bs], v[ti], 1, one);
      end else if (tc == 1 && bc == 1) begin
        for (int i = 0; i < 3; i++)
          if (i != ti && i != bi && mi < 0) mi = i;
        ht = v[ti][1] - v[bi][1];
        if (mi >= 0 && ht > 0) begin
          r = ((v[ti][1] - v[mi][1]) * (longint'(1) << tssg_pkg::RATIO_FRAC)) / ht;
          sp[0] = clamp(v[ti][0] - (((v[ti][0] - v[bi][0]) * r) >>> tssg_pkg::RATIO_FRAC),
                        COORD_MIN, COORD_MAX);
          sp[1] = v[mi][1];
          sp[2] = clamp(v[ti][2] - (((v[ti][2] - v[bi][2]) * r) >>> tssg_pkg::RATIO_FRAC),
                        COORD_MIN, COORD_MAX);
          walk_half(v[mi], sp, v[ti], 1, one);
          walk_half(v[mi], sp, v[bi], 0, one);
        end
      end
      if (fresh.size() > 0) begin
        fresh[fresh.size()-1].last = 1;
        fresh[fresh.size()-1].trunc = cut;
      end
      foreach (fresh[i]) spans_due.push_back(fresh[i]);
    endfunction

    function void check_span(span_t got);
      span_t want;
      if (spans_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected span, expected none, actual %p", $realtime, got);
        return;
      end
      want = spans_due.pop_front();
      if (got !== want) begin
        errors++;
        $display("%0t: span mismatch, expected %p, actual %p", $realtime, want, got);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_we = 0;
  logic [tssg_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [tssg_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  tssg_in_if  #(COORD_BITS) tri_ch();
  tssg_out_if #(COORD_BITS) span_ch();

  triangle_scanline_span_generator_core #(
    .MAX_SPANS(MAX_SPANS), .COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)
  ) u_top (
    .clk(clk), .rst_n(rst_n), .in_if(tri_ch), .out_if(span_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  span_scoreboard book = new();
  int send_idle_pct = 34;
  int recv_idle_pct = 82;
  bit hold_req = 0;
  int hold_left = 0;

  initial begin
    tri_ch.valid = 0;
    tri_ch.vert_a_x = '0; tri_ch.vert_a_y = '0; tri_ch.vert_a_z = '0;
    tri_ch.vert_b_x = '0; tri_ch.vert_b_y = '0; tri_ch.vert_b_z = '0;
    tri_ch.vert_c_x = '0; tri_ch.vert_c_y = '0; tri_ch.vert_c_z = '0;
    span_ch.ready = 0;
  end

  // receiver: random stalls plus one long hold-off on request
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      span_ch.ready = 0;
      hold_left--;
    end else begin
      span_ch.ready = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    tri_t t;
    span_t s;
    if (rst_n && tri_ch.valid && tri_ch.ready) begin
      t.p[0][0] = tri_ch.vert_a_x; t.p[0][1] = tri_ch.vert_a_y; t.p[0][2] = tri_ch.vert_a_z;
      t.p[1][0] = tri_ch.vert_b_x; t.p[1][1] = tri_ch.vert_b_y; t.p[1][2] = tri_ch.vert_b_z;
      t.p[2][0] = tri_ch.vert_c_x; t.p[2][1] = tri_ch.vert_c_y; t.p[2][2] = tri_ch.vert_c_z;
      book.note_triangle(t);
    end
    if (rst_n && span_ch.valid && span_ch.ready) begin
      s.y = span_ch.span_y;
      s.start_x = span_ch.span_start_x; s.start_z = span_ch.span_start_z;
      s.end_x = span_ch.span_end_x; s.end_z = span_ch.span_end_z;
      s.red = span_ch.span_red; s.green = span_ch.span_green; s.blue = span_ch.span_blue;
      s.last = span_ch.last_span; s.trunc = span_ch.truncated;
      book.check_span(s);
    end
  end

  // entered at a falling edge, leaves at a falling edge
  task automatic send_triangle(tri_t t);
    while ($urandom_range(99) < send_idle_pct) begin
      tri_ch.valid = 0;
      @(negedge clk);
    end
    tri_ch.vert_a_x = t.p[0][0]; tri_ch.vert_a_y = t.p[0][1]; tri_ch.vert_a_z = t.p[0][2];
    tri_ch.vert_b_x = t.p[1][0]; tri_ch.vert_b_y = t.p[1][1]; tri_ch.vert_b_z = t.p[1][2];
    tri_ch.vert_c_x = t.p[2][0]; tri_ch.vert_c_y = t.p[2][1]; tri_ch.vert_c_z = t.p[2][2];
    tri_ch.valid = 1;
    do @(posedge clk); while (!tri_ch.ready);
    @(negedge clk);
  endtask

  task automatic write_reg(tssg_pkg::cfg_idx_t idx, int unsigned value);
    cfg_we = 1;
    cfg_index = idx;
    cfg_data = value[tssg_pkg::CFG_DATA_W-1:0];
    @(negedge clk);
    cfg_we = 0;
    case (idx)
      tssg_pkg::CFG_ROW_STEP:   book.row_step = value & 32'hffff;
      tssg_pkg::CFG_MIN_HEIGHT: book.min_height = value & 32'h7fffff;
      tssg_pkg::CFG_RED:        book.red = value[7:0];
      tssg_pkg::CFG_GREEN:      book.green = value[7:0];
      tssg_pkg::CFG_BLUE:       book.blue = value[7:0];
      default: ;
    endcase
  endtask

  // wait for every span owed, then for a triangle that may still be silently in flight
  task automatic drain();
    tri_ch.valid = 0;
    while (book.spans_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic coord_t rand_coord(int kind);
    case (kind)
      0: return coord_t'(int'($urandom_range(8191)) - 4096);
      1: return coord_t'($urandom);
      default: begin
        case ($urandom_range(3))
          0: return coord_t'(COORD_MIN);
          1: return coord_t'(COORD_MAX);
          2: return '0;
          default: return '1;
        endcase
      end
    endcase
  endfunction

  function automatic tri_t rand_triangle();
    tri_t t;
    int kind, pick, a, b;
    pick = $urandom_range(99);
    kind = pick < 75 ? 0 : (pick < 90 ? 1 : 2);
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) t.p[i][j] = rand_coord($urandom_range(9) == 0 ? 2 : kind);
    pick = $urandom_range(99);
    if (pick < 5) begin
      t.p[1][1] = t.p[0][1];
      t.p[2][1] = t.p[0][1];
    end else if (pick < 35) begin
      a = $urandom_range(2);
      b = (a + 1 + $urandom_range(1)) % 3;
      t.p[b][1] = t.p[a][1];
    end
    return t;
  endfunction

  function automatic tri_t make_tri(int ax, int ay, int az, int bx, int by, int bz,
                                    int cx, int cy, int cz);
    tri_t t;
    t.p[0][0] = coord_t'(ax); t.p[0][1] = coord_t'(ay); t.p[0][2] = coord_t'(az);
    t.p[1][0] = coord_t'(bx); t.p[1][1] = coord_t'(by); t.p[1][2] = coord_t'(bz);
    t.p[2][0] = coord_t'(cx); t.p[2][1] = coord_t'(cy); t.p[2][2] = coord_t'(cz);
    return t;
  endfunction

  task automatic send_random(int n);
    for (int i = 0; i < n; i++) send_triangle(rand_triangle());
  endtask

  localparam int LO = -8388608;
  localparam int HI = 8388607;

  initial begin
    repeat (11) @(negedge clk);
    rst_n = 1;
    @(negedge clk);

    // directed: flat top, flat bottom, split, degenerate, ties, extremes
    send_triangle(make_tri(0, 2560, 0, 2560, 2560, 512, 1280, 0, -512));
    send_triangle(make_tri(0, 0, 0, 2560, 0, 256, 1280, 2560, 100));
    send_triangle(make_tri(100, 3000, 7, -900, 0, 40, 2000, 1100, -300));
    send_triangle(make_tri(5, 777, 1, 9, 777, 2, -3, 777, 3));
    send_triangle(make_tri(0, 512, 0, 256, 0, 0, 512, 512, 0));
    send_triangle(make_tri(0, 0, 0, 256, 512, 0, 512, 0, 0));
    send_triangle(make_tri(0, 100, 0, 50, 200, 9, 90, 300, 3));
    send_triangle(make_tri(0, 0, 0, 10, 1, 0, 20, 2, 0));
    send_triangle(make_tri(LO, LO, LO, HI, HI, HI, 0, 0, 0));
    send_triangle(make_tri(HI, HI, LO, LO, HI, HI, 0, LO, 0));
    send_triangle(make_tri(LO, LO, HI, HI, LO, LO, HI, HI, HI));
    send_triangle(make_tri(HI, 0, HI, LO, 1, LO, 0, -1, 0));
    send_triangle(make_tri(0, LO, 0, HI, HI, LO, LO, 300, HI));
    send_triangle(make_tri(-1, -1, -1, -1, -1, -1, 0, 0, 0));
    send_triangle(make_tri(0, 0, 0, 0, 256, 0, 0, 257, 0));
    send_triangle(make_tri(300, 20000, 0, -300, 0, 0, 0, 10000, 0));
    drain();

    // short halves and small steps
    write_reg(tssg_pkg::CFG_ROW_STEP, 64);
    write_reg(tssg_pkg::CFG_MIN_HEIGHT, 300);
    write_reg(tssg_pkg::CFG_RED, $urandom_range(255));
    write_reg(tssg_pkg::CFG_GREEN, $urandom_range(255));
    write_reg(tssg_pkg::CFG_BLUE, $urandom_range(255));
    send_triangle(make_tri(0, 0, 0, 100, 300, 0, 50, 301, 0));
    send_triangle(make_tri(0, 0, 0, 100, 301, 0, 50, 700, 0));
    send_random(15);
    drain();

    send_idle_pct = 82;
    recv_idle_pct = 34;
    write_reg(tssg_pkg::CFG_ROW_STEP, 1);
    write_reg(tssg_pkg::CFG_MIN_HEIGHT, 0);
    write_reg(tssg_pkg::CFG_RED, 0);
    write_reg(tssg_pkg::CFG_GREEN, 255);
    write_reg(tssg_pkg::CFG_BLUE, 0);
    send_random(15);
    drain();

    write_reg(tssg_pkg::CFG_ROW_STEP, 65535);
    write_reg(tssg_pkg::CFG_MIN_HEIGHT, 8388607);
    send_random(6);
    drain();
    write_reg(tssg_pkg::CFG_MIN_HEIGHT, 0);
    send_random(15);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(tssg_pkg::CFG_ROW_STEP, 200);
    write_reg(tssg_pkg::CFG_RED, 255);
    write_reg(tssg_pkg::CFG_GREEN, 0);
    write_reg(tssg_pkg::CFG_BLUE, 255);
    hold_req = 1;
    send_random(30);
    drain();
    write_reg(tssg_pkg::CFG_ROW_STEP, 256);
    send_random(20);
    drain();

    if (book.errors == 0 && book.spans_due.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("status: fail");
    $finish;
  end
endmodule
`default_nettype wire

// File: triangle_scanline_span_generator_core.f
+incdir+hdl
hdl/tssg_pkg.sv
hdl/tssg_ifs.sv
hdl/tssg_div.sv
hdl/triangle_scanline_span_generator_core.sv
bench/testbench.sv
